[hdl/bilinear_image_scaler_assert.svh]
// Assertion macros shared by the scaler's checking code.
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BIS_CHECK_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BIS_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bis_pkg.sv]
package bis_pkg;

    localparam int DEF_MAX_DIM   = 256;
    localparam int DEF_FRAC_BITS = 16;

    localparam int COORD_W     = 8;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 32;
    localparam int STEP_W      = 24;
    localparam int SIZE_REG_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 32;
    localparam int LANES       = 4;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_MUL,
        ST_LOC,
        ST_FETCH,
        ST_FIN
    } bis_state_t;

    // Corner order matches the weight order: top-left, top-right, bottom-left, bottom-right
    typedef enum logic [1:0] {
        CRN_00,
        CRN_10,
        CRN_01,
        CRN_11
    } bis_corner_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_STEP_X,
        REG_STEP_Y
    } bis_reg_t;

    typedef struct packed {
        logic        capture;
        logic        write_px;
        logic        mul;
        logic        locate;
        logic        rd_en;
        bis_corner_t rd_corner;
        logic        acc_en;
        logic        acc_bottom;
        logic        finish;
    } bis_cmd_t;

    typedef struct packed {
        logic out_busy;
    } bis_status_t;

endpackage

[hdl/bis_ram.sv]
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bis_ctrl.sv]
module bis_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_mode,
    output logic                  in_ready,
    input  bis_pkg::bis_status_t  status,
    output bis_pkg::bis_cmd_t     cmd
);

    localparam logic [2:0] K_LAST = 3'd4;

    bis_pkg::bis_state_t state_reg, state_next;
    logic [2:0]          k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bis_pkg::ST_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            bis_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = (in_mode == bis_pkg::MODE_LOAD) ? bis_pkg::ST_WRITE
                                                                  : bis_pkg::ST_MUL;
                end
            end
            bis_pkg::ST_WRITE:
            begin
                cmd.write_px = 1'b1;
                state_next   = bis_pkg::ST_IDLE;
            end
            bis_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = bis_pkg::ST_LOC;
            end
            bis_pkg::ST_LOC:
            begin
                cmd.locate = 1'b1;
                k_next     = '0;
                state_next = bis_pkg::ST_FETCH;
            end
            bis_pkg::ST_FETCH:
            begin
                // read corner k while the previous corner's data is accumulated
                cmd.rd_en      = (k_reg != K_LAST);
                cmd.rd_corner  = bis_pkg::bis_corner_t'(k_reg[1:0]);
                cmd.acc_en     = (k_reg != 3'd0);
                cmd.acc_bottom = (k_reg == 3'd3) || (k_reg == K_LAST);
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = bis_pkg::ST_FIN;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            bis_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = bis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bis_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/bis_datapath.sv]
module bis_datapath #(
    parameter int MAX_DIM   = bis_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = bis_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bis_pkg::bis_cmd_t                 cmd,
    output bis_pkg::bis_status_t              status,
    input  logic [bis_pkg::IN_DATA_W-1:0]     in_data,
    input  logic                              cfg_valid,
    input  logic [bis_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bis_pkg::OUT_DATA_W-1:0]    out_data
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int SIZE_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W   = (SIZE_W > bis_pkg::SIZE_REG_W) ? SIZE_W : bis_pkg::SIZE_REG_W;
    localparam int PROD_W  = bis_pkg::COORD_W + bis_pkg::STEP_W;
    localparam int IP_W    = PROD_W - FRAC_BITS;
    localparam int CMPI_W  = (IP_W > DIM_W) ? IP_W : DIM_W;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int WPROD_W = 2 * WGT_W;
    localparam int ACC_W   = FRAC_BITS + bis_pkg::CHAN_W + 1;
    localparam int SUM_W   = ACC_W - FRAC_BITS + 1;
    localparam int CW      = bis_pkg::CHAN_W;

    localparam logic [WGT_W-1:0]  ONE      = WGT_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0]  HALF     = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [CMP_W-1:0]  MAX_SIZE = CMP_W'(MAX_DIM);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_DIM);
    localparam logic [SUM_W-1:0]  CHAN_MAX = SUM_W'((1 << CW) - 1);

    typedef struct packed {
        logic [DIM_W-1:0]     lo;
        logic [DIM_W-1:0]     hi;
        logic [FRAC_BITS-1:0] frac;
    } loc_t;

    // configuration
    logic [bis_pkg::SIZE_REG_W-1:0] src_width_reg, src_height_reg;
    logic [bis_pkg::STEP_W-1:0]     step_x_reg, step_y_reg;

    // captured item
    logic [bis_pkg::COORD_W-1:0] col_reg, row_reg;
    logic [bis_pkg::PIX_W-1:0]   pix_reg;

    logic [PROD_W-1:0]    gx_reg, gy_reg;
    logic [DIM_W-1:0]     x0_reg, x1_reg, y0_reg, y1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic [WGT_W-1:0]     w_reg;
    logic [ACC_W-1:0]     top_reg [bis_pkg::LANES];
    logic [ACC_W-1:0]     bot_reg [bis_pkg::LANES];
    logic [bis_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_valid_reg;

    logic [DIM_W-1:0]   last_x, last_y;
    loc_t               loc_x, loc_y;
    logic [WGT_W-1:0]   wa, wb;
    logic [WPROD_W-1:0] wprod;
    logic [DIM_W-1:0]   rd_x, rd_y;
    logic [ADDR_W-1:0]  ram_addr;
    logic               load_ok;
    logic               ram_we;
    logic [bis_pkg::PIX_W-1:0] ram_rdata;

    function automatic logic [DIM_W-1:0] last_index(input logic [bis_pkg::SIZE_REG_W-1:0] s);
        logic [CMP_W-1:0] se;
        se = CMP_W'(s);
        if (se == '0)
        begin
            last_index = '0;
        end
        else if (se > MAX_SIZE)
        begin
            last_index = DIM_W'(MAX_SIZE - CMP_W'(1));
        end
        else
        begin
            last_index = DIM_W'(se - CMP_W'(1));
        end
    endfunction

    function automatic loc_t locate(input logic [PROD_W-1:0] g, input logic [DIM_W-1:0] last);
        logic [IP_W-1:0] ip;
        loc_t            r;
        ip = g[PROD_W-1:FRAC_BITS];
        if (CMPI_W'(ip) > CMPI_W'(last))
        begin
            // past the image: clamp to the edge and drop the fraction
            r.lo   = last;
            r.frac = '0;
        end
        else
        begin
            r.lo   = DIM_W'(ip);
            r.frac = g[FRAC_BITS-1:0];
        end
        r.hi = (r.lo < last) ? r.lo + DIM_W'(1) : r.lo;
        locate = r;
    endfunction

    assign last_x = last_index(src_width_reg);
    assign last_y = last_index(src_height_reg);
    assign loc_x  = locate(gx_reg, last_x);
    assign loc_y  = locate(gy_reg, last_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= bis_pkg::SIZE_REG_W'(1);
            src_height_reg <= bis_pkg::SIZE_REG_W'(1);
            step_x_reg     <= '0;
            step_y_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (bis_pkg::bis_reg_t'(cfg_index))
                bis_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[bis_pkg::SIZE_REG_W-1:0];
                bis_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[bis_pkg::SIZE_REG_W-1:0];
                bis_pkg::REG_STEP_X:     step_x_reg     <= cfg_data;
                bis_pkg::REG_STEP_Y:     step_y_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // weight of the corner being read, one product per cycle
    always_comb
    begin
        unique case (cmd.rd_corner)
            bis_pkg::CRN_00:
            begin
                wa = ONE - WGT_W'(fx_reg);
                wb = ONE - WGT_W'(fy_reg);
            end
            bis_pkg::CRN_10:
            begin
                wa = WGT_W'(fx_reg);
                wb = ONE - WGT_W'(fy_reg);
            end
            bis_pkg::CRN_01:
            begin
                wa = ONE - WGT_W'(fx_reg);
                wb = WGT_W'(fy_reg);
            end
            bis_pkg::CRN_11:
            begin
                wa = WGT_W'(fx_reg);
                wb = WGT_W'(fy_reg);
            end
            default:
            begin
                wa = '0;
                wb = '0;
            end
        endcase
        wprod = WPROD_W'(wa) * WPROD_W'(wb);
        rd_x  = (cmd.rd_corner == bis_pkg::CRN_10 || cmd.rd_corner == bis_pkg::CRN_11)
                ? x1_reg : x0_reg;
        rd_y  = (cmd.rd_corner == bis_pkg::CRN_01 || cmd.rd_corner == bis_pkg::CRN_11)
                ? y1_reg : y0_reg;
    end

    assign load_ok = (32'(col_reg) < MAX_DIM) && (32'(row_reg) < MAX_DIM);
    assign ram_we  = cmd.write_px && load_ok;

    always_comb
    begin
        if (cmd.write_px)
        begin
            ram_addr = ADDR_W'(ADDR_W'(row_reg) * ROW_STEP + ADDR_W'(col_reg));
        end
        else
        begin
            ram_addr = ADDR_W'(ADDR_W'(rd_y) * ROW_STEP + ADDR_W'(rd_x));
        end
    end

    bis_ram #(
        .WIDTH (bis_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pix_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= in_data[bis_pkg::COORD_W-1:0];
            row_reg <= in_data[2*bis_pkg::COORD_W-1:bis_pkg::COORD_W];
            pix_reg <= in_data[bis_pkg::IN_DATA_W-1:2*bis_pkg::COORD_W];
        end
        if (cmd.mul)
        begin
            gx_reg <= PROD_W'(col_reg) * PROD_W'(step_x_reg);
            gy_reg <= PROD_W'(row_reg) * PROD_W'(step_y_reg);
        end
        if (cmd.locate)
        begin
            x0_reg <= loc_x.lo;
            x1_reg <= loc_x.hi;
            fx_reg <= loc_x.frac;
            y0_reg <= loc_y.lo;
            y1_reg <= loc_y.hi;
            fy_reg <= loc_y.frac;
        end
        if (cmd.rd_en)
        begin
            w_reg <= WGT_W'(wprod >> FRAC_BITS);
        end
        for (int i = 0; i < bis_pkg::LANES; i++)
        begin
            if (cmd.locate)
            begin
                top_reg[i] <= '0;
                bot_reg[i] <= HALF;
            end
            else if (cmd.acc_en)
            begin
                if (cmd.acc_bottom)
                begin
                    bot_reg[i] <= bot_reg[i] + ACC_W'(ram_rdata[i*CW +: CW]) * ACC_W'(w_reg);
                end
                else
                begin
                    top_reg[i] <= top_reg[i] + ACC_W'(ram_rdata[i*CW +: CW]) * ACC_W'(w_reg);
                end
            end
        end
        if (cmd.finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        for (int i = 0; i < bis_pkg::LANES; i++)
        begin
            sum = SUM_W'(top_reg[i] >> FRAC_BITS) + SUM_W'(bot_reg[i] >> FRAC_BITS);
            out_data_next[i*CW +: CW] = (sum > CHAN_MAX) ? CW'(CHAN_MAX) : CW'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

[hdl/bilinear_image_scaler.sv]
// Load item: written to the pixel RAM in the cycle after acceptance; no item is taken while one is in flight.
// Request item: steps through MUL, LOC, FETCH and FIN, waiting in FIN while the output is busy.
// The request time is set by the four serial reads of the single-port pixel RAM, one
// shared weight multiplier, and the position multiply and clamp stages ahead of them.
// rst_n clears control, config registers (width 1, height 1, steps 0) and output valid;
// pixel RAM contents are not cleared.
`include "bilinear_image_scaler_assert.svh"

module bilinear_image_scaler #(
    parameter int MAX_DIM   = bis_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = bis_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bis_pkg::IN_DATA_W-1:0]   s_tdata,   // col, row, in_red, in_green, in_blue, in_alpha
    input  logic                            s_tuser,   // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bis_pkg::OUT_DATA_W-1:0]  m_tdata,   // out_red, out_green, out_blue, out_alpha
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bis_pkg::bis_cmd_t    cmd;
    bis_pkg::bis_status_t status;

    assign cfg_ready = 1'b1;

    bis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bis_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `BIS_CHECK_IMP(a_no_write_during_read, cmd.write_px, !cmd.rd_en, "pixel write overlaps a corner read")
    `BIS_CHECK_NEXT(a_busy_after_transfer, s_tvalid && s_tready, !s_tready, "input taken while item in flight")
    `BIS_CHECK_IMP(a_finish_slot_free, cmd.finish, !m_tvalid || m_tready, "result overwrites a pending transfer")
    `BIS_CHECK_IMP(a_valid_from_finish, $rose(m_tvalid), $past(cmd.finish), "output valid without a finished request")

endmodule
